// ----- hw/rtl/dfa_pkg.sv -----
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared types and constants for the table-driven DFA block.
// ----------------------------------------------------------------------------
package dfa_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned STATE_BITS  = 4;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned MASK_W      = 1 << STATE_BITS;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // item commands
  typedef enum logic [1:0] {
    CMD_FEED    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START   = 2'd0,
    REG_ACCEPT  = 2'd1,
    REG_ENTRIES = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_e;

  localparam logic [STATE_BITS-1:0] START_RST   = STATE_BITS'(1);
  localparam logic [MASK_W-1:0]     ACCEPT_RST  = MASK_W'(2);
  localparam logic [CNT_W-1:0]      ENTRIES_RST = '0;

  // controller to datapath
  typedef struct packed {
    logic capture;  // input word taken, search compares registered
    logic commit;   // apply the item and load the output word
  } dfa_cmd_t;

endpackage

// ----- hw/rtl/dfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfa_ctrl
// Sequencer: takes a word, commits it once the output register is free.
// ----------------------------------------------------------------------------
module dfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dfa_pkg::dfa_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take, commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;
  // output register free, or being drained this cycle
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = take;
  assign cmd_o.commit  = commit;

endmodule

// ----- hw/rtl/dfa_datapath.sv -----
// ----------------------------------------------------------------------------
// dfa_datapath
// Transition table, parallel entry compare, state/error and output registers.
// ----------------------------------------------------------------------------
module dfa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dfa_pkg::dfa_cmd_t                   cmd_i,
  input  logic                                cfg_we_i,
  input  logic [dfa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dfa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [1:0]                          cmd_word_i,
  input  logic [dfa_pkg::SYM_W-1:0]           symbol_i,
  input  logic [dfa_pkg::IDX_W-1:0]           entry_index_i,
  input  logic [dfa_pkg::STATE_BITS-1:0]      entry_from_i,
  input  logic [dfa_pkg::SYM_W-1:0]           entry_symbol_i,
  input  logic [dfa_pkg::STATE_BITS-1:0]      entry_to_i,
  output logic [dfa_pkg::STATE_BITS-1:0]      current_o,
  output logic                                accepted_o,
  output logic                                error_o
);

  // configuration
  logic [dfa_pkg::STATE_BITS-1:0] start_q;
  logic [dfa_pkg::MASK_W-1:0]     accept_q;
  logic [dfa_pkg::CNT_W-1:0]      used_q;

  // automaton state
  logic [dfa_pkg::STATE_BITS-1:0] state_q, state_d;
  logic                           fault_q, fault_d;

  // transition table
  logic [dfa_pkg::STATE_BITS-1:0] from_q [dfa_pkg::ENTRIES];
  logic [dfa_pkg::SYM_W-1:0]      sym_q  [dfa_pkg::ENTRIES];
  logic [dfa_pkg::STATE_BITS-1:0] to_q   [dfa_pkg::ENTRIES];

  // captured word
  dfa_pkg::cmd_e                  op_q;
  logic [dfa_pkg::IDX_W-1:0]      idx_q;
  logic [dfa_pkg::STATE_BITS-1:0] efrom_q, eto_q;
  logic [dfa_pkg::SYM_W-1:0]      esym_q;
  logic [dfa_pkg::ENTRIES-1:0]    hit_q, hit_d;

  // output word
  logic [dfa_pkg::STATE_BITS-1:0] current_q;
  logic                           accepted_q, error_q;

  logic [dfa_pkg::IDX_W-1:0]      sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= dfa_pkg::START_RST;
      accept_q <= dfa_pkg::ACCEPT_RST;
      used_q   <= dfa_pkg::ENTRIES_RST;
    end else if (cfg_we_i) begin
      unique case (dfa_pkg::reg_e'(cfg_idx_i))
        dfa_pkg::REG_START:   start_q  <= cfg_data_i[dfa_pkg::STATE_BITS-1:0];
        dfa_pkg::REG_ACCEPT:  accept_q <= cfg_data_i[dfa_pkg::MASK_W-1:0];
        dfa_pkg::REG_ENTRIES: used_q   <= cfg_data_i[dfa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // every entry below the in-use count compared against the present state and symbol
  always_comb begin
    for (int i = 0; i < dfa_pkg::ENTRIES; i++) begin
      hit_d[i] = (dfa_pkg::CNT_W'(i) < used_q) && (from_q[i] == state_q) &&
                 (sym_q[i] == symbol_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= dfa_pkg::cmd_e'(cmd_word_i);
      idx_q   <= entry_index_i;
      efrom_q <= entry_from_i;
      esym_q  <= entry_symbol_i;
      eto_q   <= entry_to_i;
      hit_q   <= hit_d;
    end
  end

  // lowest matching index wins
  always_comb begin
    sel = '0;
    for (int i = dfa_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (hit_q[i]) sel = dfa_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    fault_d = fault_q;
    case (op_q)
      dfa_pkg::CMD_FEED: begin
        if (!fault_q) begin
          if (|hit_q) state_d = to_q[sel];
          else        fault_d = 1'b1;
        end
      end
      dfa_pkg::CMD_RESTART: begin
        state_d = start_q;
        fault_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfa_pkg::START_RST;
      fault_q <= 1'b0;
    end else if (cmd_i.commit) begin
      state_q <= state_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && op_q == dfa_pkg::CMD_WRITE) begin
      from_q[idx_q] <= efrom_q;
      sym_q[idx_q]  <= esym_q;
      to_q[idx_q]   <= eto_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      current_q  <= state_d;
      accepted_q <= !fault_d && accept_q[state_d];
      error_q    <= fault_d;
    end
  end

  assign current_o  = current_q;
  assign accepted_o = accepted_q;
  assign error_o    = error_q;

endmodule

// ----- hw/rtl/table_driven_dfa.sv -----
// ----------------------------------------------------------------------------
// table_driven_dfa
// Deterministic finite automaton stepped through a loadable transition table.
//
//   channel  direction  handshake                   word
//   in       input      in_valid_i / in_ready_o     cmd, symbol, entry fields
//   out      output     out_valid_o / out_ready_i   current, accepted, error
//   cfg      input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// For each word, the accept edge registers all entry compares, and the commit
// edge then picks the lowest hit and updates state, table and output.
// The commit waits while the output register holds an untaken word.
// Reset restores the configuration defaults, start state and error flag;
// the transition table has no reset and must be written before it is searched.
// ----------------------------------------------------------------------------
module table_driven_dfa (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dfa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dfa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [dfa_pkg::SYM_W-1:0]           symbol_i,
  input  logic [dfa_pkg::IDX_W-1:0]           entry_index_i,
  input  logic [dfa_pkg::STATE_BITS-1:0]      entry_from_i,
  input  logic [dfa_pkg::SYM_W-1:0]           entry_symbol_i,
  input  logic [dfa_pkg::STATE_BITS-1:0]      entry_to_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dfa_pkg::STATE_BITS-1:0]      current_o,
  output logic                                accepted_o,
  output logic                                error_o
);

  dfa_pkg::dfa_cmd_t ctl;

  dfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (ctl)
  );

  dfa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_word_i     (cmd_i),
    .symbol_i       (symbol_i),
    .entry_index_i  (entry_index_i),
    .entry_from_i   (entry_from_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_to_i     (entry_to_i),
    .current_o      (current_o),
    .accepted_o     (accepted_o),
    .error_o        (error_o)
  );

endmodule
